/* src/itkf_pkg.sv */
// ----------------------------------------------------------------------------
// itkf_pkg
// Shared types, constants and helpers for the IMU tilt Kalman fusion block.
// ----------------------------------------------------------------------------
package itkf_pkg;

   localparam int FILTER_AXES_DEF  = 2;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_Q_ANGLE   = 2'd0,
      CSR_Q_BIAS    = 2'd1,
      CSR_R_MEASURE = 2'd2
   } csr_index_type;

   localparam logic [31:0] Q_ANGLE_RST   = 32'd16777;
   localparam logic [31:0] Q_BIAS_RST    = 32'd50332;
   localparam logic [31:0] R_MEASURE_RST = 32'd503316;

   // sample interval handling
   localparam logic [31:0] US_MAX     = 32'd1000000;
   localparam logic [31:0] US_DEFAULT = 32'd10000;
   localparam int          DT_W       = 25;
   // dt = 16*us + (12144*us + 7812) / 15625, same as round(us * 2^24 / 10^6)
   localparam int          DT_FRAC_MUL = 12144;
   localparam int          DT_FRAC_ADD = 7812;
   localparam int          DT_FRAC_DEN = 15625;
   // floor(2^34 / 15625): estimate is exact or one low
   localparam int          DT_RECIP    = 1099511;

   // gain division: |cov| * 2^24 over the innovation variance
   localparam int GAIN_NUM_W = 56;
   localparam int GAIN_DEN_W = 33;

   localparam logic signed [31:0] ANGLE_180 = 32'sd11796480;

   typedef struct packed {
      logic [31:0] q_angle;
      logic [31:0] q_bias;
      logic [31:0] r_measure;
   } itkf_cfg_type;

   typedef struct packed {
      logic signed [31:0] meas0;
      logic signed [31:0] meas1;
      logic signed [31:0] gyro0;
      logic signed [31:0] gyro1;
      logic [DT_W-1:0]    dt;
   } itkf_item_type;

   // atan(2^-i) in degrees, Q16.16
   function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
      logic signed [31:0] v;
      case (i)
         5'd0:    v = 32'sd2949120;
         5'd1:    v = 32'sd1740967;
         5'd2:    v = 32'sd919879;
         5'd3:    v = 32'sd466945;
         5'd4:    v = 32'sd234379;
         5'd5:    v = 32'sd117304;
         5'd6:    v = 32'sd58666;
         5'd7:    v = 32'sd29335;
         5'd8:    v = 32'sd14668;
         5'd9:    v = 32'sd7334;
         5'd10:   v = 32'sd3667;
         5'd11:   v = 32'sd1833;
         5'd12:   v = 32'sd917;
         5'd13:   v = 32'sd458;
         5'd14:   v = 32'sd229;
         5'd15:   v = 32'sd115;
         5'd16:   v = 32'sd57;
         5'd17:   v = 32'sd29;
         5'd18:   v = 32'sd14;
         5'd19:   v = 32'sd7;
         5'd20:   v = 32'sd4;
         5'd21:   v = 32'sd2;
         5'd22:   v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [63:0] zx64(input logic [31:0] v);
      return {32'b0, v};
   endfunction

endpackage

/* src/itkf_div.sv */
// ----------------------------------------------------------------------------
// itkf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itkf_div #(
   parameter int NUM_W = 45,
   parameter int DEN_W = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   rem_sh;
   logic             fits;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      fits   = rem_sh >= {1'b0, den_ff};
      if (fits) begin
         rem_in = DEN_W'(rem_sh - {1'b0, den_ff});
      end else begin
         rem_in = rem_sh[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         cnt_ff  <= CNT_W'(NUM_W);
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         // dividend shifts out the top while quotient bits shift in
         num_ff <= {num_ff[NUM_W-2:0], fits};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign quo  = num_ff;

endmodule

/* src/itkf_front.sv */
// ----------------------------------------------------------------------------
// itkf_front
// Accepts an IMU sample, forms dt, the pitch and roll tilt angles
// (integer sqrt then CORDIC) and hands a filter request to the queue.
// ----------------------------------------------------------------------------
module itkf_front import itkf_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   input  logic signed [31:0]  req_gyro_rate_x,
   input  logic signed [31:0]  req_gyro_rate_y,
   input  logic [31:0]         req_elapsed_us,
   output logic                q_push,
   output itkf_item_type       q_item,
   input  logic                q_full
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_SQRT,
      F_CORDIC,
      F_WAIT
   } state_type;

   typedef struct packed {
      logic signed [27:0] x;
      logic signed [27:0] y;
      logic signed [31:0] z;
   } lane_type;

   function automatic lane_type lane_init(input logic signed [27:0] y,
                                          input logic signed [27:0] x);
      lane_type l;
      l.x = x;
      l.y = y;
      l.z = '0;
      // left half plane: rotate by 180 degrees first
      if (x < 0) begin
         l.x = -x;
         l.y = -y;
         l.z = (y >= 0) ? ANGLE_180 : -ANGLE_180;
      end
      return l;
   endfunction

   function automatic lane_type lane_step(input lane_type l, input logic [4:0] i);
      lane_type n;
      logic signed [27:0] dx;
      logic signed [27:0] dy;
      dx = l.y >>> i;
      dy = l.x >>> i;
      n  = l;
      if (l.y >= 0) begin
         n.x = l.x + dx;
         n.y = l.y - dy;
         n.z = l.z + atan_deg(i);
      end else begin
         n.x = l.x - dx;
         n.y = l.y + dy;
         n.z = l.z - atan_deg(i);
      end
      return n;
   endfunction

   state_type          state_ff;
   logic signed [15:0] ax_ff;
   logic signed [15:0] ay_ff;
   logic signed [15:0] az_ff;
   logic signed [31:0] gx_ff;
   logic signed [31:0] gy_ff;
   logic [47:0]        n_ff;
   logic [47:0]        r_ff;
   logic [47:0]        bit_ff;
   lane_type           lane0_ff;
   lane_type           lane1_ff;
   logic               zero0_ff;
   logic               zero1_ff;
   logic [4:0]         step_ff;
   logic [19:0]        us_ff;
   logic [33:0]        dt_y_ff;
   logic [19:0]        dt_q0_ff;
   logic [DT_W-1:0]    dt_ff;

   logic                accept;
   logic [31:0]         us_fix;
   logic [33:0]         dt_y;
   logic [54:0]         dt_prod;
   logic [34:0]         dt_rem;
   logic                dt_fix;
   logic signed [31:0]  axsq;
   logic signed [31:0]  azsq;
   logic [31:0]         sq_sum;
   logic [47:0]         sq_try;
   logic                sq_fit;
   logic [47:0]         r_in;
   logic [47:0]         n_in;
   logic signed [27:0]  y0_init;
   logic signed [27:0]  x0_init;
   logic signed [27:0]  y1_init;
   logic signed [27:0]  x1_init;

   assign accept = push && (state_ff == F_IDLE);
   assign full   = state_ff != F_IDLE;

   always_comb begin
      if (req_elapsed_us == 32'd0 || req_elapsed_us > US_MAX) begin
         us_fix = US_DEFAULT;
      end else begin
         us_fix = req_elapsed_us;
      end
      dt_y   = 34'(us_fix[19:0]) * 34'(DT_FRAC_MUL) + 34'(DT_FRAC_ADD);
      axsq   = 32'(req_accel_x) * 32'(req_accel_x);
      azsq   = 32'(req_accel_z) * 32'(req_accel_z);
      sq_sum = unsigned'(axsq) + unsigned'(azsq);
   end

   // dt pipeline: reciprocal estimate, then one correction step
   always_comb begin
      dt_prod = 55'(dt_y_ff) * 55'(DT_RECIP);
      dt_rem  = 35'(dt_y_ff) - 35'(dt_q0_ff) * 35'(DT_FRAC_DEN);
      dt_fix  = dt_rem >= 35'(DT_FRAC_DEN);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         us_ff   <= us_fix[19:0];
         dt_y_ff <= dt_y;
      end
      dt_q0_ff <= dt_prod[53:34];
      dt_ff    <= DT_W'({us_ff, 4'b0}) + DT_W'(dt_q0_ff) + DT_W'(dt_fix);
   end

   always_comb begin
      sq_try = r_ff + bit_ff;
      sq_fit = n_ff >= sq_try;
      if (sq_fit) begin
         n_in = n_ff - sq_try;
         r_in = (r_ff >> 1) + bit_ff;
      end else begin
         n_in = n_ff;
         r_in = r_ff >> 1;
      end
      y0_init = {{4{ay_ff[15]}}, ay_ff, 8'b0};
      x0_init = {4'b0, r_in[23:0]};
      x1_init = {{4{az_ff[15]}}, az_ff, 8'b0};
      y1_init = -{{4{ax_ff[15]}}, ax_ff, 8'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  ax_ff    <= req_accel_x;
                  ay_ff    <= req_accel_y;
                  az_ff    <= req_accel_z;
                  gx_ff    <= req_gyro_rate_x;
                  gy_ff    <= req_gyro_rate_y;
                  n_ff     <= {sq_sum, 16'b0};
                  r_ff     <= '0;
                  bit_ff   <= {2'b01, 46'b0};
                  state_ff <= F_SQRT;
               end
            end
            F_SQRT: begin
               n_ff   <= n_in;
               r_ff   <= r_in;
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  lane0_ff <= lane_init(y0_init, x0_init);
                  lane1_ff <= lane_init(y1_init, x1_init);
                  zero0_ff <= (x0_init == 28'sd0) && (y0_init == 28'sd0);
                  zero1_ff <= (x1_init == 28'sd0) && (y1_init == 28'sd0);
                  step_ff  <= '0;
                  state_ff <= F_CORDIC;
               end
            end
            F_CORDIC: begin
               lane0_ff <= lane_step(lane0_ff, step_ff);
               lane1_ff <= lane_step(lane1_ff, step_ff);
               step_ff  <= step_ff + 5'd1;
               if (step_ff == 5'(CORDIC_STEPS - 1)) begin
                  state_ff <= F_WAIT;
               end
            end
            F_WAIT: begin
               if (q_push) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign q_push = (state_ff == F_WAIT) && !q_full;

   always_comb begin
      q_item.meas0 = zero0_ff ? 32'sd0 : lane0_ff.z;
      q_item.meas1 = zero1_ff ? 32'sd0 : lane1_ff.z;
      q_item.gyro0 = gx_ff;
      q_item.gyro1 = gy_ff;
      q_item.dt    = dt_ff;
   end

endmodule

/* src/itkf_queue.sv */
// ----------------------------------------------------------------------------
// itkf_queue
// Short request queue between the front end and the filter engine.
// ----------------------------------------------------------------------------
module itkf_queue import itkf_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  itkf_item_type wr_item,
   output logic          full,
   input  logic          rd_en,
   output itkf_item_type rd_item,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   itkf_item_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   logic do_wr;
   logic do_rd;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   assign rd_item = mem_ff[rd_ptr_ff];

endmodule

/* src/itkf_back.sv */
// ----------------------------------------------------------------------------
// itkf_back
// Per-axis angle/bias Kalman filter sequencer: one shared multiplier,
// two serial gain dividers, filter state per axis and the result register.
// ----------------------------------------------------------------------------
module itkf_back import itkf_pkg::*; #(
   parameter int FILTER_AXES = FILTER_AXES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  itkf_cfg_type       cfg,
   input  itkf_item_type      q_item,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_angle_x,
   output logic signed [31:0] rsp_angle_y
);

   // only pitch and roll are ever filtered
   localparam int LIVE_AXES = (FILTER_AXES < 2) ? FILTER_AXES : 2;
   localparam int AXIS_W    = (LIVE_AXES > 1) ? $clog2(LIVE_AXES) : 1;

   typedef enum logic [4:0] {
      B_IDLE, B_LOAD, B_RATE, B_M1, B_M2, B_M3, B_M4, B_M5, B_DIV, B_WAIT,
      B_M6, B_M7, B_M8, B_M9, B_M10, B_M11, B_M12, B_OUT
   } state_type;

   state_type          state_ff;
   logic [AXIS_W-1:0]  axis_ff;
   itkf_item_type      item_ff;

   logic signed [31:0] ang_mem_ff  [LIVE_AXES];
   logic signed [31:0] bias_mem_ff [LIVE_AXES];
   logic signed [31:0] aa_mem_ff   [LIVE_AXES];
   logic signed [31:0] ab_mem_ff   [LIVE_AXES];
   logic signed [31:0] ba_mem_ff   [LIVE_AXES];
   logic signed [31:0] bb_mem_ff   [LIVE_AXES];

   logic signed [31:0] ang_ff, bias_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [31:0] meas_ff, gyro_ff, rate_ff, t_ff, y_ff;
   logic signed [31:0] k0_ff, k1_ff, p00_ff, p01_ff;
   logic [DT_W-1:0]    dt_ff;
   logic               neg0_ff, neg1_ff;
   logic signed [65:0] prod_ff;

   logic               out_valid_ff;
   logic signed [31:0] out_x_ff, out_y_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] rnd;
   logic signed [63:0] m64;
   logic signed [32:0] dt_op;
   logic signed [31:0] rate_in, t_in, y_in;
   logic signed [31:0] ang_p, bias_p, aa_p, aa_m, ab_m, ba_m, bb_p, bb_m;
   logic signed [63:0] s_full;
   logic               s_pos;
   logic [31:0]        aa_mag, ba_mag;
   logic               div_start;
   logic               busy0, busy1;
   logic [GAIN_NUM_W-1:0] quo0, quo1;
   logic signed [63:0] q0x, q1x;
   logic signed [31:0] k0_in, k1_in;
   logic signed [31:0] res_y;

   assign dt_op = {8'b0, dt_ff};

   // operand select of the shared multiplier
   always_comb begin
      case (state_ff)
         B_M1: begin mul_a = dt_op;              mul_b = {rate_ff[31], rate_ff}; end
         B_M2: begin mul_a = dt_op;              mul_b = {bb_ff[31], bb_ff};     end
         B_M3: begin mul_a = {1'b0, cfg.q_bias}; mul_b = dt_op;                  end
         B_M4: begin mul_a = dt_op;              mul_b = {t_ff[31], t_ff};       end
         B_M6: begin mul_a = {k0_ff[31], k0_ff}; mul_b = {y_ff[31], y_ff};       end
         B_M7: begin mul_a = {k1_ff[31], k1_ff}; mul_b = {y_ff[31], y_ff};       end
         B_M8: begin mul_a = {k0_ff[31], k0_ff}; mul_b = {aa_ff[31], aa_ff};     end
         B_M9: begin mul_a = {k0_ff[31], k0_ff}; mul_b = {p01_ff[31], p01_ff};   end
         B_M10: begin mul_a = {k1_ff[31], k1_ff}; mul_b = {p00_ff[31], p00_ff};  end
         B_M11: begin mul_a = {k1_ff[31], k1_ff}; mul_b = {p01_ff[31], p01_ff};  end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      // product scaled by 2^-24, rounded half up
      rnd     = prod_ff + 66'sd8388608;
      m64     = {{22{rnd[65]}}, rnd[65:24]};
      rate_in = sat32(sx64(gyro_ff) - sx64(bias_ff));
      t_in    = sat32(m64 - sx64(ab_ff) - sx64(ba_ff) + zx64(cfg.q_angle));
      y_in    = sat32(sx64(meas_ff) - sx64(ang_ff));
      ang_p   = sat32(sx64(ang_ff) + m64);
      bias_p  = sat32(sx64(bias_ff) + m64);
      aa_p    = sat32(sx64(aa_ff) + m64);
      aa_m    = sat32(sx64(aa_ff) - m64);
      ab_m    = sat32(sx64(ab_ff) - m64);
      ba_m    = sat32(sx64(ba_ff) - m64);
      bb_p    = sat32(sx64(bb_ff) + m64);
      bb_m    = sat32(sx64(bb_ff) - m64);
      s_full  = sx64(aa_ff) + zx64(cfg.r_measure);
      s_pos   = s_full > 64'sd0;
      aa_mag  = aa_ff[31] ? 32'(-aa_ff) : aa_ff;
      ba_mag  = ba_ff[31] ? 32'(-ba_ff) : ba_ff;
      q0x     = {{(64-GAIN_NUM_W){1'b0}}, quo0};
      q1x     = {{(64-GAIN_NUM_W){1'b0}}, quo1};
      k0_in   = sat32(neg0_ff ? -q0x : q0x);
      k1_in   = sat32(neg1_ff ? -q1x : q1x);
   end

   assign div_start = (state_ff == B_DIV) && s_pos;

   itkf_div #(
      .NUM_W (GAIN_NUM_W),
      .DEN_W (GAIN_DEN_W)
   ) u_k0_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({aa_mag, 24'b0}),
      .den   (s_full[GAIN_DEN_W-1:0]),
      .busy  (busy0),
      .quo   (quo0)
   );

   itkf_div #(
      .NUM_W (GAIN_NUM_W),
      .DEN_W (GAIN_DEN_W)
   ) u_k1_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({ba_mag, 24'b0}),
      .den   (s_full[GAIN_DEN_W-1:0]),
      .busy  (busy1),
      .quo   (quo1)
   );

   generate
      if (LIVE_AXES > 1) begin : g_two
         assign res_y = ang_mem_ff[LIVE_AXES-1];
      end else begin : g_one
         assign res_y = '0;
      end
   endgenerate

   assign q_pop = (state_ff == B_IDLE) && !q_empty;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         axis_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < LIVE_AXES; i++) begin
            ang_mem_ff[i]  <= '0;
            bias_mem_ff[i] <= '0;
            aa_mem_ff[i]   <= '0;
            ab_mem_ff[i]   <= '0;
            ba_mem_ff[i]   <= '0;
            bb_mem_ff[i]   <= '0;
         end
      end else begin
         if (pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (q_pop) begin
                  item_ff  <= q_item;
                  axis_ff  <= '0;
                  state_ff <= B_LOAD;
               end
            end
            B_LOAD: begin
               ang_ff   <= ang_mem_ff[axis_ff];
               bias_ff  <= bias_mem_ff[axis_ff];
               aa_ff    <= aa_mem_ff[axis_ff];
               ab_ff    <= ab_mem_ff[axis_ff];
               ba_ff    <= ba_mem_ff[axis_ff];
               bb_ff    <= bb_mem_ff[axis_ff];
               meas_ff  <= (axis_ff == '0) ? item_ff.meas0 : item_ff.meas1;
               gyro_ff  <= (axis_ff == '0) ? item_ff.gyro0 : item_ff.gyro1;
               dt_ff    <= item_ff.dt;
               state_ff <= B_RATE;
            end
            B_RATE: begin
               rate_ff  <= rate_in;
               state_ff <= B_M1;
            end
            B_M1: state_ff <= B_M2;
            B_M2: begin
               ang_ff   <= ang_p;
               state_ff <= B_M3;
            end
            B_M3: begin
               // t uses the old cross terms
               t_ff     <= t_in;
               ab_ff    <= ab_m;
               ba_ff    <= ba_m;
               state_ff <= B_M4;
            end
            B_M4: begin
               bb_ff    <= bb_p;
               state_ff <= B_M5;
            end
            B_M5: begin
               aa_ff    <= aa_p;
               state_ff <= B_DIV;
            end
            B_DIV: begin
               y_ff    <= y_in;
               neg0_ff <= aa_ff[31];
               neg1_ff <= ba_ff[31];
               if (s_pos) begin
                  state_ff <= B_WAIT;
               end else begin
                  // innovation variance not positive: skip the update
                  k0_ff    <= '0;
                  k1_ff    <= '0;
                  state_ff <= B_M6;
               end
            end
            B_WAIT: begin
               if (!busy0 && !busy1) begin
                  k0_ff    <= k0_in;
                  k1_ff    <= k1_in;
                  state_ff <= B_M6;
               end
            end
            B_M6: state_ff <= B_M7;
            B_M7: begin
               ang_ff   <= ang_p;
               state_ff <= B_M8;
            end
            B_M8: begin
               bias_ff  <= bias_p;
               p00_ff   <= aa_ff;
               p01_ff   <= ab_ff;
               state_ff <= B_M9;
            end
            B_M9: begin
               aa_ff    <= aa_m;
               state_ff <= B_M10;
            end
            B_M10: begin
               ab_ff    <= ab_m;
               state_ff <= B_M11;
            end
            B_M11: begin
               ba_ff    <= ba_m;
               state_ff <= B_M12;
            end
            B_M12: begin
               ang_mem_ff[axis_ff]  <= ang_ff;
               bias_mem_ff[axis_ff] <= bias_ff;
               aa_mem_ff[axis_ff]   <= aa_ff;
               ab_mem_ff[axis_ff]   <= ab_ff;
               ba_mem_ff[axis_ff]   <= ba_ff;
               bb_mem_ff[axis_ff]   <= bb_m;
               if (axis_ff == AXIS_W'(LIVE_AXES - 1)) begin
                  state_ff <= B_OUT;
               end else begin
                  axis_ff  <= axis_ff + AXIS_W'(1);
                  state_ff <= B_LOAD;
               end
            end
            B_OUT: begin
               if (!out_valid_ff) begin
                  out_x_ff     <= ang_mem_ff[0];
                  out_y_ff     <= res_y;
                  out_valid_ff <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign empty       = !out_valid_ff;
   assign rsp_angle_x = out_x_ff;
   assign rsp_angle_y = out_y_ff;

endmodule

/* src/imu_tilt_kalman_fusion.sv */
// ----------------------------------------------------------------------------
// imu_tilt_kalman_fusion
// Accelerometer tilt (pitch, roll) fused with gyro rates by two-state
// angle/bias Kalman filters; results in Q16.16 degrees.
// Front end: integer sqrt, then CORDIC_STEPS CORDIC iterations, then the handoff
//   to the queue; dt is formed beside it.
// Filter engine: takes a new request only once the last result is registered;
//   it filters each axis in turn and waits on the radix-2 gain dividers.
// Reset: synchronous; filter state cleared, registers to defaults, queue empty.
// ----------------------------------------------------------------------------
module imu_tilt_kalman_fusion import itkf_pkg::*; #(
   parameter int FILTER_AXES  = FILTER_AXES_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic signed [15:0]    req_accel_x,
   input  logic signed [15:0]    req_accel_y,
   input  logic signed [15:0]    req_accel_z,
   input  logic signed [31:0]    req_gyro_rate_x,
   input  logic signed [31:0]    req_gyro_rate_y,
   input  logic [31:0]           req_elapsed_us,
   output logic                  empty,
   input  logic                  pop,
   output logic signed [31:0]    rsp_angle_x,
   output logic signed [31:0]    rsp_angle_y,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   itkf_cfg_type  cfg_ff;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   itkf_item_type q_wr_item;
   itkf_item_type q_rd_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.q_angle   <= Q_ANGLE_RST;
         cfg_ff.q_bias    <= Q_BIAS_RST;
         cfg_ff.r_measure <= R_MEASURE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_Q_ANGLE:   cfg_ff.q_angle   <= csr_wr_data;
            CSR_Q_BIAS:    cfg_ff.q_bias    <= csr_wr_data;
            CSR_R_MEASURE: cfg_ff.r_measure <= csr_wr_data;
            default: ;
         endcase
      end
   end

   itkf_front #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .req_gyro_rate_x (req_gyro_rate_x),
      .req_gyro_rate_y (req_gyro_rate_y),
      .req_elapsed_us  (req_elapsed_us),
      .q_push          (q_push),
      .q_item          (q_wr_item),
      .q_full          (q_full)
   );

   itkf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (q_wr_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_item (q_rd_item),
      .empty   (q_empty)
   );

   itkf_back #(
      .FILTER_AXES (FILTER_AXES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_item      (q_rd_item),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_angle_x (rsp_angle_x),
      .rsp_angle_y (rsp_angle_y)
   );

endmodule

/* bench/itkf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itkf_checker
// Watches the request, response and register ports of the tilt fusion block,
// keeps its own copy of the two-axis angle/bias filters and compares every
// response against the expected angles, oldest first.
// ----------------------------------------------------------------------------
module itkf_checker import itkf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  logic signed [15:0]    req_accel_x,
   input  logic signed [15:0]    req_accel_y,
   input  logic signed [15:0]    req_accel_z,
   input  logic signed [31:0]    req_gyro_rate_x,
   input  logic signed [31:0]    req_gyro_rate_y,
   input  logic [31:0]           req_elapsed_us,
   input  logic                  empty,
   input  logic                  pop,
   input  logic signed [31:0]    rsp_angle_x,
   input  logic signed [31:0]    rsp_angle_y,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    fail_count,
   output int                    pending,
   output int                    responses_seen
);

   typedef struct {
      logic signed [31:0] pitch;
      logic signed [31:0] roll;
   } tilt_type;

   localparam longint MIN32 = -64'sd2147483648;
   localparam longint MAX32 = 64'sd2147483647;

   // atan(2^-i) in Q16.16 degrees
   localparam int ATAN_TAB [0:22] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

   tilt_type expected_tilt[$];
   logic [31:0] q_ang, q_bia, r_meas;
   longint f_angle [2];
   longint f_bias  [2];
   longint p_aa [2];
   longint p_ab [2];
   longint p_ba [2];
   longint p_bb [2];

   function automatic longint clip32(longint v);
      if (v > MAX32) return MAX32;
      if (v < MIN32) return MIN32;
      return v;
   endfunction

   function automatic longint mul_q24(longint a, longint b);
      return (a * b + (64'sd1 <<< 23)) >>> 24;
   endfunction

   function automatic longint root_floor(longint n);
      longint r, bitv;
      r = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (n >= r + bitv) begin
            n = n - (r + bitv);
            r = (r >>> 1) + bitv;
         end else begin
            r = r >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return r;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += (i < 23) ? longint'(ATAN_TAB[i]) : 64'sd0;
         end else begin
            x -= dx; y += dy; z -= (i < 23) ? longint'(ATAN_TAB[i]) : 64'sd0;
         end
      end
      return clip32(z);
   endfunction

   task automatic filter_axis(int a, longint meas, longint gyro, longint dt);
      longint rate, t, s, k0, k1, innov, p00, p01;
      k0 = 0;
      k1 = 0;
      rate = clip32(gyro - f_bias[a]);
      f_angle[a] = clip32(f_angle[a] + mul_q24(dt, rate));
      t = clip32(mul_q24(dt, p_bb[a]) - p_ab[a] - p_ba[a] + longint'(q_ang));
      p_aa[a] = clip32(p_aa[a] + mul_q24(dt, t));
      p_ab[a] = clip32(p_ab[a] - mul_q24(dt, p_bb[a]));
      p_ba[a] = clip32(p_ba[a] - mul_q24(dt, p_bb[a]));
      p_bb[a] = clip32(p_bb[a] + mul_q24(longint'(q_bia), dt));
      s = p_aa[a] + longint'(r_meas);
      // gains stay zero when the innovation variance is not positive
      if (s > 0) begin
         k0 = clip32((p_aa[a] * 16777216) / s);
         k1 = clip32((p_ba[a] * 16777216) / s);
      end
      innov = clip32(meas - f_angle[a]);
      f_angle[a] = clip32(f_angle[a] + mul_q24(k0, innov));
      f_bias[a] = clip32(f_bias[a] + mul_q24(k1, innov));
      p00 = p_aa[a];
      p01 = p_ab[a];
      p_aa[a] = clip32(p_aa[a] - mul_q24(k0, p00));
      p_ab[a] = clip32(p_ab[a] - mul_q24(k0, p01));
      p_ba[a] = clip32(p_ba[a] - mul_q24(k1, p00));
      p_bb[a] = clip32(p_bb[a] - mul_q24(k1, p01));
   endtask

   task automatic predict_tilt();
      longint ax, ay, az, us, dt, pitch_m, roll_m;
      tilt_type e;
      ax = longint'(req_accel_x);
      ay = longint'(req_accel_y);
      az = longint'(req_accel_z);
      us = longint'(req_elapsed_us);
      if (us == 0 || us > 1000000) us = 10000;
      dt = ((us <<< 24) + 500000) / 1000000;
      pitch_m = vector_angle(ay * 256, root_floor((ax * ax + az * az) <<< 16));
      roll_m = vector_angle(-ax * 256, az * 256);
      filter_axis(0, pitch_m, longint'(req_gyro_rate_x), dt);
      filter_axis(1, roll_m, longint'(req_gyro_rate_y), dt);
      e.pitch = f_angle[0][31:0];
      e.roll = f_angle[1][31:0];
      expected_tilt.push_back(e);
   endtask

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      tilt_type e;
      if (reset) begin
         q_ang = Q_ANGLE_RST;
         q_bia = Q_BIAS_RST;
         r_meas = R_MEASURE_RST;
         for (int a = 0; a < 2; a++) begin
            f_angle[a] = 0; f_bias[a] = 0;
            p_aa[a] = 0; p_ab[a] = 0; p_ba[a] = 0; p_bb[a] = 0;
         end
         expected_tilt.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_Q_ANGLE:   q_ang = csr_wr_data;
               CSR_Q_BIAS:    q_bia = csr_wr_data;
               CSR_R_MEASURE: r_meas = csr_wr_data;
               default: ;
            endcase
         end
         if (push && !full) predict_tilt();
         if (pop && !empty) begin
            responses_seen++;
            if (expected_tilt.size() == 0) begin
               report_mismatch("unexpected response", '0, rsp_angle_x);
            end else begin
               e = expected_tilt.pop_front();
               if (rsp_angle_x !== e.pitch) report_mismatch("angle_x", e.pitch, rsp_angle_x);
               if (rsp_angle_y !== e.roll) report_mismatch("angle_y", e.roll, rsp_angle_y);
            end
         end
      end
      pending = expected_tilt.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      responses_seen = 0;
   end

endmodule

/* bench/imu_tilt_kalman_fusion_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_kalman_fusion_tb
// Drives IMU samples and register settings into the tilt fusion block with
// random gaps and response stalls; a side checker predicts every response.
// ----------------------------------------------------------------------------
module imu_tilt_kalman_fusion_tb import itkf_pkg::*;;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_PER_PHASE = 310;
   localparam int IDLE_LIMIT       = 20000;
   localparam int DRAIN_CYCLES     = 300;

   typedef struct {
      logic signed [15:0] ax, ay, az;
      logic signed [31:0] gx, gy;
      logic [31:0]        us;
   } sample_type;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic signed [15:0]    req_accel_x, req_accel_y, req_accel_z;
   logic signed [31:0]    req_gyro_rate_x, req_gyro_rate_y;
   logic [31:0]           req_elapsed_us;
   logic                  empty;
   logic                  pop;
   logic signed [31:0]    rsp_angle_x, rsp_angle_y;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    fail_count, pending, responses_seen;
   int                    sent_count;
   int                    hold_cycles;
   int                    idle_cycles;
   bit                    no_gaps;

   imu_tilt_kalman_fusion u_top (.*);

   itkf_checker u_checker (.*);

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic int srange(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : int'($urandom_range(0, 5));
   endfunction

   task automatic send_sample(sample_type s);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_accel_x <= s.ax;
      req_accel_y <= s.ay;
      req_accel_z <= s.az;
      req_gyro_rate_x <= s.gx;
      req_gyro_rate_y <= s.gy;
      req_elapsed_us <= s.us;
      push <= 1'b1;
      do @(posedge clock); while (full);
      sent_count++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // block must be idle before a register write
   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic sample_type make_sample(int ax, int ay, int az, int gx, int gy,
                                              logic [31:0] us);
      sample_type s;
      s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az); s.gx = gx; s.gy = gy; s.us = us;
      return s;
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         // plausible motion: each axis within +/-16384, modest rates and intervals
         s.ax = 16'(srange(-16384, 16384));
         s.ay = 16'(srange(-16384, 16384));
         s.az = 16'(srange(-16384, 16384));
         s.gx = srange(-200 * 65536, 200 * 65536);
         s.gy = srange(-200 * 65536, 200 * 65536);
         s.us = $urandom_range(200, 20000);
      end else if (pick < 80) begin
         s.ax = ($urandom_range(0, 2) == 0) ? 16'sd0
                : (($urandom & 1) ? 16'sh7fff : 16'sh8000);
         s.ay = ($urandom_range(0, 2) == 0) ? 16'sd0
                : (($urandom & 1) ? 16'sh7fff : 16'sh8000);
         s.az = ($urandom_range(0, 2) == 0) ? 16'sd0
                : (($urandom & 1) ? 16'sh7fff : 16'sh8000);
         s.gx = ($urandom & 1) ? 32'sh7fffffff : 32'sh80000000;
         s.gy = ($urandom & 1) ? 32'sh7fffffff : 32'sh80000000;
         case ($urandom_range(0, 3))
            0: s.us = 0;
            1: s.us = US_MAX;
            2: s.us = US_MAX + 1;
            default: s.us = 32'hffffffff;
         endcase
      end else begin
         s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
         s.gx = $urandom; s.gy = $urandom; s.us = $urandom;
      end
      return s;
   endfunction

   task automatic random_phase(int count, bit with_hold);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (with_hold && i == count / 2) hold_cycles = 3000;
         send_sample(random_sample());
      end
   endtask

   // response side: random stalls, plus one long hold when asked
   initial begin
      int w;
      pop = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            w = hold_cycles;
            hold_cycles = 0;
         end else begin
            w = no_gaps ? 0 : int'($urandom_range(0, 5));
         end
         if (w > 0) begin
            pop <= 1'b0;
            repeat (w) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d responses outstanding", pending);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_Q_ANGLE;
      csr_wr_data = '0;
      req_accel_x = '0; req_accel_y = '0; req_accel_z = '0;
      req_gyro_rate_x = '0; req_gyro_rate_y = '0; req_elapsed_us = '0;
      sent_count = 0;
      hold_cycles = 0;
      idle_cycles = 0;
      no_gaps = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed samples at reset register values
      send_sample(make_sample(0, 0, 0, 0, 0, 10000));               // zero vector
      send_sample(make_sample(0, 0, -16384, 0, 0, 10000));          // flat upside down
      send_sample(make_sample(0, 0, 16384, 0, 0, 0));               // bad interval, zero
      send_sample(make_sample(0, 100, 16384, 65536, -65536, 1000000));
      send_sample(make_sample(0, 100, 16384, 65536, -65536, 1000001));
      send_sample(make_sample(100, 0, 16384, 0, 0, 32'hffffffff));
      send_sample(make_sample(0, 0, 16384, 0, 0, 1));
      send_sample(make_sample(32767, 32767, 32767, 32'sh7fffffff, 32'sh7fffffff, 5000));
      send_sample(make_sample(-32768, -32768, -32768, 32'sh80000000, 32'sh80000000, 5000));
      send_sample(make_sample(-32768, 32767, 0, 0, 0, 20000));
      send_sample(make_sample(32767, -32768, 0, 0, 0, 20000));
      send_sample(make_sample(0, 32767, 0, 0, 0, 10000));
      send_sample(make_sample(0, -32768, 0, 0, 0, 10000));
      send_sample(make_sample(16384, 0, -16384, 1000, -1000, 2500));
      send_sample(make_sample(-16384, 0, -16384, -1000, 1000, 2500));
      send_sample(make_sample(0, 0, -1, 0, 0, 10000));
      send_sample(make_sample(1, 1, 1, 1, 1, 1000000));
      send_sample(make_sample(-1, -1, -1, -1, -1, 999999));
      random_phase(RANDOM_PER_PHASE, 1'b1);

      // minimum noise settings
      wait_idle();
      write_reg(CSR_Q_ANGLE, 32'd0);
      write_reg(CSR_Q_BIAS, 32'd0);
      write_reg(CSR_R_MEASURE, 32'd1);
      random_phase(RANDOM_PER_PHASE, 1'b0);

      // maximum noise settings
      wait_idle();
      write_reg(CSR_Q_ANGLE, 32'hffffffff);
      write_reg(CSR_Q_BIAS, 32'hffffffff);
      write_reg(CSR_R_MEASURE, 32'hffffffff);
      random_phase(RANDOM_PER_PHASE, 1'b0);

      // mixed: tiny measurement noise with huge process noise
      wait_idle();
      write_reg(CSR_Q_ANGLE, 32'h80000000);
      write_reg(CSR_R_MEASURE, 32'd1);
      write_reg(CSR_SPARE, $urandom);
      random_phase(RANDOM_PER_PHASE, 1'b0);

      // random settings
      wait_idle();
      write_reg(CSR_Q_ANGLE, $urandom);
      write_reg(CSR_Q_BIAS, $urandom);
      write_reg(CSR_R_MEASURE, $urandom_range(1, 32'hffffffff));
      random_phase(RANDOM_PER_PHASE, 1'b0);

      // back to typical values
      wait_idle();
      write_reg(CSR_Q_ANGLE, Q_ANGLE_RST);
      write_reg(CSR_Q_BIAS, Q_BIAS_RST);
      write_reg(CSR_R_MEASURE, R_MEASURE_RST);
      write_reg(CSR_SPARE, 32'hffffffff);
      random_phase(RANDOM_PER_PHASE, 1'b0);

      push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d samples sent, %0d responses checked over six register settings",
               sent_count, responses_seen);
      $display("%0d mismatches, %0d responses outstanding", fail_count, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
